FILE: rtl/core/npl_pkg.sv
// Shared types and codes for the price level book: request and result words, level record.
package npl_pkg;

    localparam int PRICE_W = 64;
    localparam int QTY_W   = 31;
    localparam int CODE_W  = 3;

    // Outcome codes
    localparam logic [CODE_W-1:0] OUT_INSERTED  = 3'd0;
    localparam logic [CODE_W-1:0] OUT_UPDATED   = 3'd1;
    localparam logic [CODE_W-1:0] OUT_REPLACED  = 3'd2;
    localparam logic [CODE_W-1:0] OUT_DROPPED   = 3'd3;
    localparam logic [CODE_W-1:0] OUT_DELETED   = 3'd4;
    localparam logic [CODE_W-1:0] OUT_NOT_FOUND = 3'd5;

    // Request type codes
    localparam logic REQ_SET    = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic                      is_bid_side;
        logic signed [PRICE_W-1:0] level_price;
        logic [QTY_W-1:0]          level_qty;
        logic [QTY_W-1:0]          level_orders;
    } t_req;

    typedef struct packed {
        logic [CODE_W-1:0]         outcome;
        logic [CODE_W-1:0]         bid_count;
        logic [CODE_W-1:0]         ask_count;
        logic signed [PRICE_W-1:0] best_bid_price;
        logic [QTY_W-1:0]          best_bid_qty;
        logic signed [PRICE_W-1:0] best_ask_price;
        logic [QTY_W-1:0]          best_ask_qty;
    } t_rsp;

    typedef struct packed {
        logic                      valid;
        logic signed [PRICE_W-1:0] price;
        logic [QTY_W-1:0]          qty;
        logic [QTY_W-1:0]          orders;
    } t_level;

    localparam t_level LEVEL_ZERO = '0;

    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic is_del;
        logic is_bid;
    } t_side_ctl;

endpackage

FILE: rtl/core/npl_cell.sv
// One price level cell: holds a level, compares against the request, shifts with neighbours.
module npl_cell
    import npl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_side_ctl i_ctl,
    input  t_req      i_req,
    input  t_level    i_prev_lvl,
    input  logic      i_prev_better,
    input  t_level    i_next_lvl,
    input  logic      i_any_match,
    output t_level    o_lvl,
    output logic      o_better,
    output logic      o_match
);

    t_level r_lvl;
    t_level n_lvl;
    logic   r_better;
    logic   r_match;
    logic   w_better;

    // Strictly better price for this side; an empty cell always counts as better
    always_comb begin
        if (!r_lvl.valid) begin
            w_better = 1'b1;
        end else if (i_ctl.is_bid) begin
            w_better = (i_req.level_price > r_lvl.price);
        end else begin
            w_better = (i_req.level_price < r_lvl.price);
        end
    end

    // Register compare flags
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_better <= w_better;
            r_match  <= r_lvl.valid && (r_lvl.price == i_req.level_price);
        end
    end

    // Work out the new level: close the gap, overwrite, insert the request, or take from the better neighbour
    always_comb begin
        n_lvl = r_lvl;
        if (i_ctl.is_del) begin
            if (i_any_match && (r_match || r_better)) begin
                n_lvl = i_next_lvl;
            end
        end else if (i_any_match) begin
            if (r_match) begin
                n_lvl.qty    = i_req.level_qty;
                n_lvl.orders = i_req.level_orders;
            end
        end else if (r_better) begin
            if (i_prev_better) begin
                n_lvl = i_prev_lvl;
            end else begin
                n_lvl.valid  = 1'b1;
                n_lvl.price  = i_req.level_price;
                n_lvl.qty    = i_req.level_qty;
                n_lvl.orders = i_req.level_orders;
            end
        end
    end

    // Hold the level; only the valid bit needs reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl.valid <= 1'b0;
        end else if (i_ctl.upd_en) begin
            r_lvl.valid <= n_lvl.valid;
        end
        if (i_ctl.upd_en) begin
            r_lvl.price  <= n_lvl.price;
            r_lvl.qty    <= n_lvl.qty;
            r_lvl.orders <= n_lvl.orders;
        end
    end

    assign o_lvl    = r_lvl;
    assign o_better = r_better;
    assign o_match  = r_match;

endmodule

FILE: rtl/core/npl_side.sv
// One side of the book: a chain of level cells, its level count and the request outcome.
module npl_side
    import npl_pkg::*;
#(
    parameter int LEVELS  = 5,
    parameter int COUNT_W = $clog2(LEVELS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_side_ctl          i_ctl,
    input  t_req               i_req,
    output logic [CODE_W-1:0]  o_outcome,
    output logic [COUNT_W-1:0] o_count,
    output t_level             o_best
);

    t_level             w_lvl    [LEVELS];
    logic [LEVELS-1:0]  w_better;
    logic [LEVELS-1:0]  w_match;
    logic               w_any_match;
    logic [COUNT_W-1:0] r_count;

    assign w_any_match = |w_match;

    // Build the chain; the ends see an empty neighbour
    for (genvar k = 0; k < LEVELS; k++) begin : g_cell
        t_level w_prev;
        t_level w_next;
        logic   w_prev_better;

        if (k == 0) begin : g_first
            assign w_prev        = LEVEL_ZERO;
            assign w_prev_better = 1'b0;
        end else begin : g_inner_prev
            assign w_prev        = w_lvl[k-1];
            assign w_prev_better = w_better[k-1];
        end

        if (k == LEVELS - 1) begin : g_last
            assign w_next = LEVEL_ZERO;
        end else begin : g_inner_next
            assign w_next = w_lvl[k+1];
        end

        npl_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_req         (i_req),
            .i_prev_lvl    (w_prev),
            .i_prev_better (w_prev_better),
            .i_next_lvl    (w_next),
            .i_any_match   (w_any_match),
            .o_lvl         (w_lvl[k]),
            .o_better      (w_better[k]),
            .o_match       (w_match[k])
        );
    end

    // Decide the outcome from the registered flags; the worst cell tells whether a slot exists
    always_comb begin
        if (i_ctl.is_del) begin
            o_outcome = w_any_match ? OUT_DELETED : OUT_NOT_FOUND;
        end else if (w_any_match) begin
            o_outcome = OUT_UPDATED;
        end else if (!w_better[LEVELS-1]) begin
            o_outcome = OUT_DROPPED;
        end else if (w_lvl[LEVELS-1].valid) begin
            o_outcome = OUT_REPLACED;
        end else begin
            o_outcome = OUT_INSERTED;
        end
    end

    // Advance the level count with the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.upd_en) begin
            if (o_outcome == OUT_INSERTED) begin
                r_count <= r_count + 1'b1;
            end else if (o_outcome == OUT_DELETED) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_count = r_count;
    assign o_best  = w_lvl[0].valid ? w_lvl[0] : LEVEL_ZERO;

endmodule

FILE: rtl/core/top_n_price_level_book_unit.sv
// Top level of the price level book: request sequencing, both sides and the result register.
//
// Input channel: i_in_valid / o_in_stall carry one request word (set or delete a level
// on the bid or ask side). Output channel: o_out_valid / i_out_stall carry one result
// word per request: outcome code, level count of each side and best level of each side.
// A word moves at a clock edge where valid is high and stall is low.
// Each side is a chain of BOOK_LEVELS cells, one per price level, best level first.
// A request passes through capture, parallel compare in every cell of the chosen side,
// shift/update of the chain and result load, in that order. The input stalls until the
// result load step is done, so a new request is taken only once the last is through.
// The next request is taken while the previous result still waits in the output
// register; a held result only delays the result load step, which waits until the
// output register is free.
// Reset (i_rst_n low, synchronous) empties both sides, clears the result valid flag
// and returns the sequencer to idle.
module top_n_price_level_book_unit
    import npl_pkg::*;
#(
    parameter int BOOK_LEVELS = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_word,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_word
);

    localparam int COUNT_W = $clog2(BOOK_LEVELS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    t_req               r_req;
    logic [CODE_W-1:0]  r_outcome;
    logic               r_out_valid;
    t_rsp               r_out_word;
    t_rsp               n_out_word;
    t_side_ctl          w_bid_ctl;
    t_side_ctl          w_ask_ctl;
    logic [CODE_W-1:0]  w_bid_outcome;
    logic [CODE_W-1:0]  w_ask_outcome;
    logic [COUNT_W-1:0] w_bid_count;
    logic [COUNT_W-1:0] w_ask_count;
    logic [COUNT_W+2:0] w_bid_count_ext;
    logic [COUNT_W+2:0] w_ask_count_ext;
    t_level             w_bid_best;
    t_level             w_ask_best;
    logic               w_in_accept;
    logic               w_out_free;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);

    // Step through capture, compare, update and result load
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request word
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_req <= i_in_word;
        end
    end

    // Steer compare and update to the requested side
    always_comb begin
        w_bid_ctl.cmp_en = (r_state == ST_CMP) && r_req.is_bid_side;
        w_bid_ctl.upd_en = (r_state == ST_UPD) && r_req.is_bid_side;
        w_bid_ctl.is_del = (r_req.req_type == REQ_DELETE);
        w_bid_ctl.is_bid = 1'b1;
        w_ask_ctl.cmp_en = (r_state == ST_CMP) && !r_req.is_bid_side;
        w_ask_ctl.upd_en = (r_state == ST_UPD) && !r_req.is_bid_side;
        w_ask_ctl.is_del = (r_req.req_type == REQ_DELETE);
        w_ask_ctl.is_bid = 1'b0;
    end

    npl_side #(
        .LEVELS (BOOK_LEVELS)
    ) u_bid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_bid_ctl),
        .i_req     (r_req),
        .o_outcome (w_bid_outcome),
        .o_count   (w_bid_count),
        .o_best    (w_bid_best)
    );

    npl_side #(
        .LEVELS (BOOK_LEVELS)
    ) u_ask (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ask_ctl),
        .i_req     (r_req),
        .o_outcome (w_ask_outcome),
        .o_count   (w_ask_count),
        .o_best    (w_ask_best)
    );

    // Hold the outcome of the update step
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_outcome <= r_req.is_bid_side ? w_bid_outcome : w_ask_outcome;
        end
    end

    // Assemble the result word; counts keep their low three bits
    assign w_bid_count_ext = {3'b000, w_bid_count};
    assign w_ask_count_ext = {3'b000, w_ask_count};

    always_comb begin
        n_out_word.outcome        = r_outcome;
        n_out_word.bid_count      = w_bid_count_ext[2:0];
        n_out_word.ask_count      = w_ask_count_ext[2:0];
        n_out_word.best_bid_price = w_bid_best.price;
        n_out_word.best_bid_qty   = w_bid_best.qty;
        n_out_word.best_ask_price = w_ask_best.price;
        n_out_word.best_ask_qty   = w_ask_best.qty;
    end

    // Load the result register when free, drop valid once the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Level counts stay within the chain length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bid_count <= COUNT_W'(BOOK_LEVELS)) && (w_ask_count <= COUNT_W'(BOOK_LEVELS)))
        else $error("level count beyond chain length");

    // An empty bid side shows a zero best level
    a_empty_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bid_count == '0) |-> (w_bid_best.price == '0) && (w_bid_best.qty == '0))
        else $error("empty bid side shows a level");

    // A taken request blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input open during request processing");

    // A result load always raises output valid and reopens the input
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && w_out_free) |=> o_out_valid && !o_in_stall)
        else $error("result load did not present a word");

endmodule

FILE: tb/top_n_price_level_book_checker.sv
// Checker for the price level book: watches both channels, predicts each result word and compares.
module top_n_price_level_book_checker
    import npl_pkg::*;
#(
    parameter int LEVELS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  t_req       i_req_word,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_stall,
    input  t_rsp       i_rsp_word,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output logic [5:0] o_outcomes_seen
);

    localparam int SIDE_ASK = 0;
    localparam int SIDE_BID = 1;
    localparam int REPORT_MAX = 10;

    // Book copy: index 1 is the bid side, index 0 the ask side; slot 0 is the best level
    logic signed [PRICE_W-1:0] book_price  [2][LEVELS];
    logic [QTY_W-1:0]          book_qty    [2][LEVELS];
    logic [QTY_W-1:0]          book_orders [2][LEVELS];
    int                        book_fill   [2];

    // Result words still owed by the block, oldest first
    t_rsp due_results [$];

    // Strictly better price for the given side, signed compare
    function automatic logic outranks(logic signed [PRICE_W-1:0] a,
                                      logic signed [PRICE_W-1:0] b, logic bid);
        return bid ? (a > b) : (a < b);
    endfunction

    function automatic logic [CODE_W-1:0] set_level(int sd, logic signed [PRICE_W-1:0] price,
                                                    logic [QTY_W-1:0] qty,
                                                    logic [QTY_W-1:0] orders);
        int   i;
        int   pos;
        int   last;
        logic full;
        // Overwrite a level that is already held
        for (i = 0; i < book_fill[sd]; i++) begin
            if (book_price[sd][i] == price) begin
                book_qty[sd][i]    = qty;
                book_orders[sd][i] = orders;
                return OUT_UPDATED;
            end
        end
        // Find sorted position behind every level at least as good
        pos = 0;
        while (pos < book_fill[sd] && !outranks(price, book_price[sd][pos], sd == SIDE_BID))
            pos++;
        full = (book_fill[sd] >= LEVELS);
        if (full && pos >= LEVELS)
            return OUT_DROPPED;
        // Shift worse levels down, the worst falls off a full side
        last = full ? LEVELS - 1 : book_fill[sd];
        for (i = last; i > pos; i--) begin
            book_price[sd][i]  = book_price[sd][i-1];
            book_qty[sd][i]    = book_qty[sd][i-1];
            book_orders[sd][i] = book_orders[sd][i-1];
        end
        book_price[sd][pos]  = price;
        book_qty[sd][pos]    = qty;
        book_orders[sd][pos] = orders;
        if (full)
            return OUT_REPLACED;
        book_fill[sd]++;
        return OUT_INSERTED;
    endfunction

    function automatic logic [CODE_W-1:0] delete_level(int sd,
                                                       logic signed [PRICE_W-1:0] price);
        int i;
        int j;
        for (i = 0; i < book_fill[sd]; i++) begin
            if (book_price[sd][i] == price) begin
                // Close the gap and clear the freed slot
                for (j = i; j + 1 < book_fill[sd]; j++) begin
                    book_price[sd][j]  = book_price[sd][j+1];
                    book_qty[sd][j]    = book_qty[sd][j+1];
                    book_orders[sd][j] = book_orders[sd][j+1];
                end
                book_fill[sd]--;
                book_price[sd][book_fill[sd]]  = '0;
                book_qty[sd][book_fill[sd]]    = '0;
                book_orders[sd][book_fill[sd]] = '0;
                return OUT_DELETED;
            end
        end
        return OUT_NOT_FOUND;
    endfunction

    // Apply one request to the book copy and form the result word it should give
    function automatic t_rsp book_after_request(t_req w);
        t_rsp r;
        int   sd;
        sd = w.is_bid_side ? SIDE_BID : SIDE_ASK;
        if (w.req_type == REQ_DELETE)
            r.outcome = delete_level(sd, w.level_price);
        else
            r.outcome = set_level(sd, w.level_price, w.level_qty, w.level_orders);
        r.bid_count      = CODE_W'(book_fill[SIDE_BID]);
        r.ask_count      = CODE_W'(book_fill[SIDE_ASK]);
        r.best_bid_price = book_fill[SIDE_BID] != 0 ? book_price[SIDE_BID][0] : '0;
        r.best_bid_qty   = book_fill[SIDE_BID] != 0 ? book_qty[SIDE_BID][0] : '0;
        r.best_ask_price = book_fill[SIDE_ASK] != 0 ? book_price[SIDE_ASK][0] : '0;
        r.best_ask_qty   = book_fill[SIDE_ASK] != 0 ? book_qty[SIDE_ASK][0] : '0;
        return r;
    endfunction

    function automatic void note_mismatch(string field, logic [PRICE_W-1:0] want,
                                          logic [PRICE_W-1:0] got);
        if (o_fail_count < REPORT_MAX)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     o_checked, field, want, got);
        o_fail_count++;
    endfunction

    // Track the book on accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int sd = 0; sd < 2; sd++) begin
                book_fill[sd] = 0;
                for (int k = 0; k < LEVELS; k++) begin
                    book_price[sd][k]  = '0;
                    book_qty[sd][k]    = '0;
                    book_orders[sd][k] = '0;
                end
            end
            due_results.delete();
            o_fail_count     = 0;
            o_checked       <= 0;
            o_outcomes_seen <= '0;
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (due_results.size() == 0) begin
                    if (o_fail_count < REPORT_MAX)
                        $display("unexpected result word %h", i_rsp_word);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (i_rsp_word.outcome !== want.outcome)
                        note_mismatch("outcome", want.outcome, i_rsp_word.outcome);
                    if (i_rsp_word.bid_count !== want.bid_count)
                        note_mismatch("bid_count", want.bid_count, i_rsp_word.bid_count);
                    if (i_rsp_word.ask_count !== want.ask_count)
                        note_mismatch("ask_count", want.ask_count, i_rsp_word.ask_count);
                    if (i_rsp_word.best_bid_price !== want.best_bid_price)
                        note_mismatch("best_bid_price", want.best_bid_price,
                                      i_rsp_word.best_bid_price);
                    if (i_rsp_word.best_bid_qty !== want.best_bid_qty)
                        note_mismatch("best_bid_qty", want.best_bid_qty,
                                      i_rsp_word.best_bid_qty);
                    if (i_rsp_word.best_ask_price !== want.best_ask_price)
                        note_mismatch("best_ask_price", want.best_ask_price,
                                      i_rsp_word.best_ask_price);
                    if (i_rsp_word.best_ask_qty !== want.best_ask_qty)
                        note_mismatch("best_ask_qty", want.best_ask_qty,
                                      i_rsp_word.best_ask_qty);
                    if (want.outcome <= OUT_NOT_FOUND)
                        o_outcomes_seen[want.outcome] <= 1'b1;
                    o_checked <= o_checked + 1;
                end
            end
            if (i_req_valid && !i_req_stall)
                due_results.push_back(book_after_request(i_req_word));
        end
        // Publish how many words are still owed
        o_pending = due_results.size();
    end

endmodule

FILE: tb/tb_top_n_price_level_book_unit.sv
// Testbench top for the price level book: clock, reset, request and result stall stimulus, verdict.
module tb_top_n_price_level_book_unit;
    import npl_pkg::*;

    localparam int LEVELS      = 5;
    localparam int POOL_SIZE   = 10;
    localparam int BLOCKS      = 15;
    localparam int BLOCK_ITEMS = 96;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 20;

    localparam logic signed [PRICE_W-1:0] PRICE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [PRICE_W-1:0] PRICE_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [QTY_W-1:0]          QTY_MAX   = 31'h7FFF_FFFF;

    logic i_clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_req in_word;
    logic out_valid;
    logic out_stall;
    t_rsp out_word;

    int         fail_count;
    int         pending;
    int         checked;
    logic [5:0] outcomes_seen;

    int   cycle_count = 0;
    logic tx_quiet    = 1'b0;
    logic rx_quiet    = 1'b0;
    int   rx_hold_left;
    int   rx_draw;
    int   sent_sets   = 0;
    int   sent_deletes = 0;

    logic signed [PRICE_W-1:0] price_pool [POOL_SIZE];

    always #5 i_clk = ~i_clk;

    top_n_price_level_book_unit #(
        .BOOK_LEVELS(LEVELS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    top_n_price_level_book_checker #(
        .LEVELS(LEVELS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (in_valid),
        .i_req_stall     (in_stall),
        .i_req_word      (in_word),
        .i_rsp_valid     (out_valid),
        .i_rsp_stall     (out_stall),
        .i_rsp_word      (out_word),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_outcomes_seen (outcomes_seen)
    );

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: after each taken word hold stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall    <= 1'b0;
            rx_hold_left <= 0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            if (rx_hold_left == 1)
                out_stall <= 1'b0;
        end else if (out_valid && !out_stall) begin
            rx_draw = rx_quiet ? 0 : $urandom_range(0, 19);
            rx_hold_left <= rx_draw;
            out_stall    <= (rx_draw > 0);
        end
    end

    function automatic t_req make_req(logic kind, logic bid, logic signed [PRICE_W-1:0] price,
                                      logic [QTY_W-1:0] qty, logic [QTY_W-1:0] orders);
        t_req w;
        w.req_type     = kind;
        w.is_bid_side  = bid;
        w.level_price  = price;
        w.level_qty    = qty;
        w.level_orders = orders;
        return w;
    endfunction

    // Offer one word after a drawn gap; valid stays high until the next gap
    task automatic send_request(t_req w);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(negedge i_clk); while (in_stall);
        @(posedge i_clk);
        if (w.req_type == REQ_DELETE)
            sent_deletes++;
        else
            sent_sets++;
    endtask

    // Hold the request side until every owed result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [QTY_W-1:0] draw_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return QTY_MAX;
        return QTY_W'($urandom());
    endfunction

    // Keep the extremes in the pool, refresh the rest
    task automatic refill_pool();
        price_pool[0] = PRICE_MIN;
        price_pool[1] = PRICE_MAX;
        price_pool[2] = '0;
        price_pool[3] = -64'sd1;
        for (int k = 4; k < POOL_SIZE; k++)
            price_pool[k] = ($urandom_range(0, 1) != 0) ? {$urandom(), $urandom()}
                                                         : PRICE_W'($urandom_range(0, 40)) - 20;
    endtask

    initial begin
        int                        del_pct;
        int                        mode;
        logic                      kind;
        logic signed [PRICE_W-1:0] price;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty sides, extreme prices, full sides, every outcome
        send_request(make_req(REQ_DELETE, 1'b0, '0, '0, '0));
        send_request(make_req(REQ_DELETE, 1'b1, PRICE_MAX, QTY_MAX, QTY_MAX));
        send_request(make_req(REQ_SET, 1'b1, '0, 31'd10, 31'd1));
        send_request(make_req(REQ_SET, 1'b1, PRICE_MIN, QTY_MAX, QTY_MAX));
        send_request(make_req(REQ_SET, 1'b1, PRICE_MAX, 31'd1, 31'd1));
        send_request(make_req(REQ_SET, 1'b1, -64'sd1, '0, '0));
        send_request(make_req(REQ_SET, 1'b1, 64'sd1, 31'd7, 31'd2));
        send_request(make_req(REQ_SET, 1'b1, 64'sd5, 31'd55, 31'd5));
        send_request(make_req(REQ_SET, 1'b1, PRICE_MIN, 31'd3, 31'd3));
        send_request(make_req(REQ_SET, 1'b1, '0, QTY_MAX, QTY_MAX));
        send_request(make_req(REQ_SET, 1'b0, PRICE_MAX, QTY_MAX, 31'd1));
        send_request(make_req(REQ_SET, 1'b0, PRICE_MIN, '0, QTY_MAX));
        send_request(make_req(REQ_SET, 1'b0, '0, 31'd20, 31'd4));
        send_request(make_req(REQ_SET, 1'b0, 64'sd7, 31'd70, 31'd7));
        send_request(make_req(REQ_SET, 1'b0, -64'sd7, 31'd17, 31'd6));
        send_request(make_req(REQ_SET, 1'b0, 64'sd100, 31'd100, 31'd9));
        send_request(make_req(REQ_SET, 1'b0, PRICE_MAX, 31'd8, 31'd8));
        send_request(make_req(REQ_DELETE, 1'b1, PRICE_MAX, QTY_MAX, '0));
        send_request(make_req(REQ_DELETE, 1'b1, -64'sd1, 31'd5, 31'd5));
        send_request(make_req(REQ_DELETE, 1'b1, 64'sd12345, '0, QTY_MAX));
        send_request(make_req(REQ_DELETE, 1'b0, PRICE_MIN, QTY_MAX, QTY_MAX));
        wait_drained();

        // Random: mostly prices from a small pool so levels are hit, updated and deleted
        refill_pool();
        for (int blk = 0; blk < BLOCKS; blk++) begin
            mode     = $urandom_range(0, 3);
            tx_quiet = (mode == 0);
            rx_quiet = (mode == 0) || (mode == 1);
            del_pct  = $urandom_range(10, 65);
            if (blk % 5 == 4)
                refill_pool();
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                kind  = ($urandom_range(0, 99) < del_pct) ? REQ_DELETE : REQ_SET;
                price = ($urandom_range(0, 99) < 88) ? price_pool[$urandom_range(0, POOL_SIZE-1)]
                                                     : {$urandom(), $urandom()};
                send_request(make_req(kind, 1'($urandom()), price, draw_qty(), draw_qty()));
            end
            if (blk % 4 == 3)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("summary: %0d set and %0d delete requests sent, %0d results checked",
                 sent_sets, sent_deletes, checked);
        $display("summary: outcome codes seen (bit per code) %b, %0d mismatches",
                 outcomes_seen, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
